[rtl/core/bsasp_pkg.sv]
// Shared constants, types and helpers for the shortest-angle step planner.
`timescale 1ns / 1ps
`default_nettype none

package bsasp_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int Q16_SHIFT       = 16 - ANGLE_FRAC_BITS;

    localparam int ANG_W   = 18;
    localparam int SCALE_W = 24;
    localparam int STEP_W  = 16;
    localparam int POS_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 4;

    // internal Q16 degree word; holds position * degrees_per_step plus wraps
    localparam int DW = 60;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = POS_W + 1;
    localparam int MUL_B_W = SCALE_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [DW-1:0] Q16_360 = DW'(360 * 65536);

    localparam logic [STAT_W-1:0] STATUS_MOVED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BELOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DEG = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_STEP = 4'd3;

    localparam logic signed [ANG_W-1:0] UPPER_RESET = 18'sd91904;
    localparam logic signed [ANG_W-1:0] LOWER_RESET = -18'sd91904;
    localparam logic [SCALE_W-1:0] SPD_RESET = 24'd291271;
    localparam logic [SCALE_W-1:0] DPS_RESET = 24'd14746;

    typedef struct packed {
        logic signed [ANG_W-1:0] upper_limit;
        logic signed [ANG_W-1:0] lower_limit;
        logic [SCALE_W-1:0]      spd_q16;
        logic [SCALE_W-1:0]      dps_q16;
    } cfg_t;

    function automatic logic signed [DW-1:0] to_q16(input logic signed [ANG_W-1:0] a);
        logic signed [DW-1:0] ext;
        ext = DW'(a);
        return ext <<< Q16_SHIFT;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return (v < 0) ? DW'(-v) : DW'(v);
    endfunction

endpackage

`default_nettype wire

[rtl/core/bsasp_req_if.sv]
// Request channel: one target angle per request.
`timescale 1ns / 1ps
`default_nettype none

interface bsasp_req_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bsasp_pkg::ANG_W-1:0]     target_angle;

    modport source (output valid, output target_angle, input ready);
    modport sink   (input valid, input target_angle, output ready);
endinterface

`default_nettype wire

[rtl/core/bsasp_rsp_if.sv]
// Result channel: status, direction, step count and new position.
`timescale 1ns / 1ps
`default_nettype none

interface bsasp_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [bsasp_pkg::STAT_W-1:0]           status;
    logic                                   direction;
    logic [bsasp_pkg::STEP_W-1:0]           step_count;
    logic signed [bsasp_pkg::POS_W-1:0]     position_now;

    modport source (output valid, output status, output direction, output step_count,
                    output position_now, input ready);
    modport sink   (input valid, input status, input direction, input step_count,
                    input position_now, output ready);
endinterface

`default_nettype wire

[rtl/core/bsasp_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface bsasp_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [bsasp_pkg::CFG_IDX_W-1:0]        reg_index;
    logic [bsasp_pkg::SCALE_W-1:0]          write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

[rtl/core/bsasp_cfg_regs.sv]
// Configuration register file: bounds and step scale factors.
`timescale 1ns / 1ps
`default_nettype none

module bsasp_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bsasp_cfg_if.sink        cfg,
    output bsasp_pkg::cfg_t  regs
);

    bsasp_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.upper_limit <= bsasp_pkg::UPPER_RESET;
            regs_reg.lower_limit <= bsasp_pkg::LOWER_RESET;
            regs_reg.spd_q16     <= bsasp_pkg::SPD_RESET;
            regs_reg.dps_q16     <= bsasp_pkg::DPS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                bsasp_pkg::REG_UPPER_BOUND:
                    regs_reg.upper_limit <= cfg.write_data[bsasp_pkg::ANG_W-1:0];
                bsasp_pkg::REG_LOWER_BOUND:
                    regs_reg.lower_limit <= cfg.write_data[bsasp_pkg::ANG_W-1:0];
                bsasp_pkg::REG_STEPS_PER_DEG:
                    regs_reg.spd_q16 <= cfg.write_data;
                bsasp_pkg::REG_DEG_PER_STEP:
                    regs_reg.dps_q16 <= cfg.write_data;
                default:
                    ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/bsasp_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module bsasp_mul (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic signed [bsasp_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [bsasp_pkg::MUL_B_W-1:0]  b,
    output logic signed [bsasp_pkg::MUL_P_W-1:0]       prod
);

    logic signed [bsasp_pkg::MUL_P_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_reg <= '0;
        else
            prod_reg <= a * b;
    end

endmodule

`default_nettype wire

[rtl/core/bounded_shortest_angle_step_planner_core.sv]
// Top level: sequencer and datapath of the shortest-angle step planner.
// Sequencer: an out-of-range target is rejected in S_MUL_POS, a move below one step
// ends after S_MUL_HI, and a move walks one 60-bit add/compare per state and makes
// three passes through the shared 33x25 multiplier.
// One plan at a time, taken only in S_IDLE; a new request is taken while a result waits.
// Reset: asynchronous active-low; position clears to zero, registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none

module bounded_shortest_angle_step_planner_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsasp_req_if.sink  req,
    bsasp_rsp_if.source rsp,
    bsasp_cfg_if.sink  cfg
);

    localparam int DW = bsasp_pkg::DW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_POS,
        S_CUR,
        S_WRAP,
        S_D2,
        S_SWAP,
        S_SUM,
        S_CHOOSE,
        S_MAG,
        S_MUL_HI,
        S_MUL_LO,
        S_ACC,
        S_FINISH
    } state_t;

    state_t state_reg;

    bsasp_pkg::cfg_t cfg_regs;

    logic signed [bsasp_pkg::ANG_W-1:0]   target_reg;
    logic signed [bsasp_pkg::POS_W-1:0]   pos_reg;
    logic signed [DW-1:0]                 cur_reg;
    logic signed [DW-1:0]                 rel_reg;
    logic signed [DW-1:0]                 d1_reg;
    logic signed [DW-1:0]                 d2_reg;
    logic signed [DW-1:0]                 sum_reg;
    logic [DW-2:0]                        m_reg;
    logic [bsasp_pkg::MUL_P_W-1:0]        acc_reg;
    logic [bsasp_pkg::STAT_W-1:0]         status_reg;
    logic                                 dir_reg;
    logic [bsasp_pkg::STEP_W-1:0]         count_reg;

    logic                                 out_valid_reg;
    logic [bsasp_pkg::STAT_W-1:0]         out_status_reg;
    logic                                 out_dir_reg;
    logic [bsasp_pkg::STEP_W-1:0]         out_count_reg;
    logic signed [bsasp_pkg::POS_W-1:0]   out_pos_reg;

    logic signed [bsasp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bsasp_pkg::MUL_B_W-1:0] mul_b;
    logic signed [bsasp_pkg::MUL_P_W-1:0] mul_p;

    logic signed [DW-1:0]                 tq;
    logic signed [DW-1:0]                 cur_ext;
    logic signed [DW-1:0]                 diff_a;
    logic signed [DW-1:0]                 diff_b;
    logic signed [DW-1:0]                 lo_q;
    logic signed [DW-1:0]                 hi_q;
    logic                                 outside;
    logic [bsasp_pkg::MUL_P_W:0]          steps_sum;
    logic [bsasp_pkg::STEP_W-1:0]         steps_sat;
    logic                                 out_load;

    bsasp_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    bsasp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MUL_POS:
            begin
                mul_a = bsasp_pkg::MUL_A_W'(pos_reg);
                mul_b = $signed({1'b0, cfg_regs.dps_q16});
            end
            S_MUL_HI:
            begin
                mul_a = bsasp_pkg::MUL_A_W'(m_reg[DW-2:32]);
                mul_b = $signed({1'b0, cfg_regs.spd_q16});
            end
            S_MUL_LO:
            begin
                mul_a = $signed({1'b0, m_reg[31:0]});
                mul_b = $signed({1'b0, cfg_regs.spd_q16});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        tq        = bsasp_pkg::to_q16(target_reg);
        cur_ext   = DW'(mul_p);
        diff_a    = tq - rel_reg;
        diff_b    = tq + bsasp_pkg::Q16_360 - rel_reg;
        lo_q      = bsasp_pkg::to_q16(cfg_regs.lower_limit);
        hi_q      = bsasp_pkg::to_q16(cfg_regs.upper_limit);
        outside   = (sum_reg < lo_q) || (sum_reg > hi_q);
        // low partial product contributes only its bits above 2^32
        steps_sum = {1'b0, acc_reg}
                  + (bsasp_pkg::MUL_P_W + 1)'(mul_p[bsasp_pkg::MUL_P_W-1:32]);
        steps_sat = (steps_sum > (bsasp_pkg::MUL_P_W + 1)'(16'hFFFF))
                  ? 16'hFFFF : steps_sum[bsasp_pkg::STEP_W-1:0];
        out_load  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.direction    = out_dir_reg;
    assign rsp.step_count   = out_count_reg;
    assign rsp.position_now = out_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            target_reg     <= '0;
            pos_reg        <= '0;
            cur_reg        <= '0;
            rel_reg        <= '0;
            d1_reg         <= '0;
            d2_reg         <= '0;
            sum_reg        <= '0;
            m_reg          <= '0;
            acc_reg        <= '0;
            status_reg     <= bsasp_pkg::STATUS_MOVED;
            dir_reg        <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= bsasp_pkg::STATUS_MOVED;
            out_dir_reg    <= 1'b0;
            out_count_reg  <= '0;
            out_pos_reg    <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        target_reg <= req.target_angle;
                        state_reg  <= S_MUL_POS;
                    end
                end
                S_MUL_POS:
                begin
                    if ((target_reg < cfg_regs.lower_limit) ||
                        (target_reg > cfg_regs.upper_limit))
                    begin
                        status_reg <= bsasp_pkg::STATUS_RANGE;
                        dir_reg    <= 1'b0;
                        count_reg  <= '0;
                        state_reg  <= S_FINISH;
                    end
                    else
                        state_reg <= S_CUR;
                end
                S_CUR:
                begin
                    cur_reg   <= cur_ext;
                    rel_reg   <= (cur_ext < 0) ? cur_ext + bsasp_pkg::Q16_360 : cur_ext;
                    state_reg <= S_WRAP;
                end
                S_WRAP:
                begin
                    d1_reg    <= (diff_a < 0) ? diff_b : diff_a;
                    state_reg <= S_D2;
                end
                S_D2:
                begin
                    d2_reg    <= d1_reg - bsasp_pkg::Q16_360;
                    state_reg <= S_SWAP;
                end
                S_SWAP:
                begin
                    if (bsasp_pkg::mag(d1_reg) > bsasp_pkg::mag(d2_reg))
                    begin
                        d1_reg <= d2_reg;
                        d2_reg <= d1_reg;
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg   <= cur_reg + d1_reg;
                    state_reg <= S_CHOOSE;
                end
                S_CHOOSE:
                begin
                    // d1_reg now holds the chosen move
                    if (outside)
                        d1_reg <= d2_reg;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    dir_reg   <= (d1_reg > 0);
                    m_reg     <= (DW-1)'(bsasp_pkg::mag(d1_reg));
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    if (m_reg < (DW-1)'(cfg_regs.dps_q16))
                    begin
                        status_reg <= bsasp_pkg::STATUS_BELOW;
                        count_reg  <= '0;
                        state_reg  <= S_FINISH;
                    end
                    else
                        state_reg <= S_MUL_LO;
                end
                S_MUL_LO:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    status_reg <= bsasp_pkg::STATUS_MOVED;
                    count_reg  <= steps_sat;
                    if (dir_reg)
                        pos_reg <= pos_reg + bsasp_pkg::POS_W'(steps_sat);
                    else
                        pos_reg <= pos_reg - bsasp_pkg::POS_W'(steps_sat);
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_status_reg <= status_reg;
                        out_dir_reg    <= dir_reg;
                        out_count_reg  <= count_reg;
                        out_pos_reg    <= pos_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_pos_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ACC) |=> $stable(pos_reg))
        else $error("position changed outside the step update");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while a plan is in progress");

    a_no_steps_unless_moved: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != bsasp_pkg::STATUS_MOVED)) |-> (rsp.step_count == '0))
        else $error("nonzero step count on a rejected or sub-step request");

    a_range_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == bsasp_pkg::STATUS_RANGE)) |-> !rsp.direction)
        else $error("direction set on an out-of-range result");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("result presented without finishing a plan");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the shortest-angle step planner core.
`timescale 1ns / 1ps

module tb_top;

    localparam longint ANG_MAX     = 360 * (1 << bsasp_pkg::ANGLE_FRAC_BITS);
    localparam int     CYCLE_LIMIT = 500000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     IDLE_PCT    = 18;

    typedef struct packed {
        logic [bsasp_pkg::STAT_W-1:0] status;
        logic                         direction;
        logic [bsasp_pkg::STEP_W-1:0] step_count;
        logic [bsasp_pkg::POS_W-1:0]  position_now;
    } plan_t;

    // Tracks register contents and position; predicts one move plan per request.
    class plan_scoreboard;
        longint                     upper;
        longint                     lower;
        longint unsigned            spd;
        longint unsigned            dps;
        bit [bsasp_pkg::POS_W-1:0]  pos;
        plan_t                      due[$];
        int                         errors;
        int                         checked;
        int                         n_moved;
        int                         n_below;
        int                         n_range;

        function new();
            upper   = bsasp_pkg::UPPER_RESET;
            lower   = bsasp_pkg::LOWER_RESET;
            spd     = bsasp_pkg::SPD_RESET;
            dps     = bsasp_pkg::DPS_RESET;
            pos     = '0;
            errors  = 0;
            checked = 0;
            n_moved = 0;
            n_below = 0;
            n_range = 0;
        endfunction

        function void note_write(logic [bsasp_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bsasp_pkg::SCALE_W-1:0] data);
            case (idx)
                bsasp_pkg::REG_UPPER_BOUND:   upper = $signed(data[bsasp_pkg::ANG_W-1:0]);
                bsasp_pkg::REG_LOWER_BOUND:   lower = $signed(data[bsasp_pkg::ANG_W-1:0]);
                bsasp_pkg::REG_STEPS_PER_DEG: spd   = data;
                bsasp_pkg::REG_DEG_PER_STEP:  dps   = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_request(logic signed [bsasp_pkg::ANG_W-1:0] target);
            longint          tgt;
            longint          cur;
            longint          rel;
            longint          diff;
            longint          d1;
            longint          d2;
            longint          d;
            longint          lo;
            longint          hi;
            longint unsigned m;
            longint unsigned steps;
            plan_t           e;
            tgt = target;
            e.status = bsasp_pkg::STATUS_RANGE;
            e.direction = 1'b0;
            e.step_count = '0;
            if (tgt >= lower && tgt <= upper) begin
                lo = lower <<< bsasp_pkg::Q16_SHIFT;
                hi = upper <<< bsasp_pkg::Q16_SHIFT;
                cur = longint'($signed(pos)) * longint'(dps);
                rel = (cur < 0) ? cur + longint'(bsasp_pkg::Q16_360) : cur;
                diff = (tgt <<< bsasp_pkg::Q16_SHIFT) - rel;
                if (diff < 0)
                    diff = diff + longint'(bsasp_pkg::Q16_360);
                d1 = diff;
                d2 = diff - longint'(bsasp_pkg::Q16_360);
                if (((d1 < 0) ? -d1 : d1) > ((d2 < 0) ? -d2 : d2))
                begin
                    d  = d1;
                    d1 = d2;
                    d2 = d;
                end
                // shorter way only if it keeps the axis inside the bounds
                d = (cur + d1 < lo || cur + d1 > hi) ? d2 : d1;
                e.direction = (d > 0);
                m = (d < 0) ? -d : d;
                if (m < dps)
                begin
                    e.status = bsasp_pkg::STATUS_BELOW;
                end
                else
                begin
                    steps = (m >> 32) * spd + (((m & 64'hFFFF_FFFF) * spd) >> 32);
                    if (steps > 65535)
                        steps = 65535;
                    e.status = bsasp_pkg::STATUS_MOVED;
                    e.step_count = steps[bsasp_pkg::STEP_W-1:0];
                    if (e.direction)
                        pos = pos + steps[bsasp_pkg::POS_W-1:0];
                    else
                        pos = pos - steps[bsasp_pkg::POS_W-1:0];
                end
            end
            e.position_now = pos;
            case (e.status)
                bsasp_pkg::STATUS_MOVED: n_moved++;
                bsasp_pkg::STATUS_BELOW: n_below++;
                default:                 n_range++;
            endcase
            due.push_back(e);
        endfunction

        // one line per mismatch
        task report(string field, longint got, longint want);
            errors++;
            $display("[%0t] %s mismatch: got %0d, want %0d", $time, field, got, want);
        endtask

        task check(plan_t got);
            plan_t want;
            checked++;
            if (due.size() == 0)
            begin
                report("result without request", 1, 0);
            end
            else
            begin
                want = due.pop_front();
                if (got.status !== want.status)
                    report("status", got.status, want.status);
                if (got.direction !== want.direction)
                    report("direction", got.direction, want.direction);
                if (got.step_count !== want.step_count)
                    report("step_count", got.step_count, want.step_count);
                if (got.position_now !== want.position_now)
                    report("position_now", $signed(got.position_now),
                           $signed(want.position_now));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    int   hold_asks;
    int   cycle_count = 0;
    int   settings;
    int   sent;

    plan_scoreboard sb;

    bsasp_req_if req();
    bsasp_rsp_if rsp();
    bsasp_cfg_if cfg();

    bounded_shortest_angle_step_planner_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        plan_t got;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                sb.note_write(cfg.reg_index, cfg.write_data);
            if (req.valid && req.ready)
                sb.note_request(req.target_angle);
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.direction, rsp.step_count, rsp.position_now};
                sb.check(got);
            end
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != seen)
            begin
                seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (calm)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic logic signed [bsasp_pkg::ANG_W-1:0] clamp_angle(longint v);
        if (v > ANG_MAX)
            v = ANG_MAX;
        if (v < -ANG_MAX)
            v = -ANG_MAX;
        return bsasp_pkg::ANG_W'(v);
    endfunction

    function automatic logic signed [bsasp_pkg::ANG_W-1:0] pick_target();
        longint lo;
        longint hi;
        longint here;
        int     r;
        r = $urandom_range(0, 99);
        lo = (sb.lower - 512 < -ANG_MAX) ? -ANG_MAX : sb.lower - 512;
        hi = (sb.upper + 512 > ANG_MAX) ? ANG_MAX : sb.upper + 512;
        if (r < 8)
        begin
            case ($urandom_range(0, 5))
                0: return clamp_angle(ANG_MAX);
                1: return clamp_angle(-ANG_MAX);
                2: return clamp_angle(sb.upper);
                3: return clamp_angle(sb.lower);
                4: return clamp_angle(sb.upper + 1);
                default: return clamp_angle(sb.lower - 1);
            endcase
        end
        else if (r < 18 || lo > hi)
        begin
            return clamp_angle(longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX);
        end
        else if (r < 32)
        begin
            // close to where the axis sits now: sub-step and short moves
            here = (longint'($signed(sb.pos)) * longint'(sb.dps)) >>> bsasp_pkg::Q16_SHIFT;
            return clamp_angle(here + longint'($urandom_range(0, 600)) - 300);
        end
        return clamp_angle(lo + longint'($urandom_range(0, int'(hi - lo))));
    endfunction

    task automatic send_target(input logic signed [bsasp_pkg::ANG_W-1:0] t);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            req.target_angle <= bsasp_pkg::ANG_W'($urandom);
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.target_angle <= t;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [bsasp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bsasp_pkg::SCALE_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.reg_index <= idx;
        cfg.write_data <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_setting(input longint ub, input longint lb,
                                 input longint unsigned spd_v, input longint unsigned dps_v);
        wait_drain();
        // bits above the 18-bit bound field carry junk
        write_reg(bsasp_pkg::REG_UPPER_BOUND, {6'($urandom), 18'(ub)});
        write_reg(bsasp_pkg::REG_LOWER_BOUND, {6'($urandom), 18'(lb)});
        write_reg(bsasp_pkg::REG_STEPS_PER_DEG, bsasp_pkg::SCALE_W'(spd_v));
        write_reg(bsasp_pkg::REG_DEG_PER_STEP, bsasp_pkg::SCALE_W'(dps_v));
        write_reg(bsasp_pkg::CFG_IDX_W'($urandom_range(int'(bsasp_pkg::REG_DEG_PER_STEP) + 1,
                                                       (1 << bsasp_pkg::CFG_IDX_W) - 1)),
                  bsasp_pkg::SCALE_W'($urandom));
        cfg.valid <= 1'b0;
        settings++;
    endtask

    task automatic run_targets(input int n, input int pause_at);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_drain();
            send_target(pick_target());
        end
    endtask

    initial
    begin : stimulus
        int              opening_targets[];
        longint          ub;
        longint          lb;
        longint          a;
        longint          b;
        longint unsigned spd_v;
        longint unsigned dps_v;

        opening_targets = '{0, 256, 1, 91904, 92160, -91904, -92160,
                            46080, -46079, 23040, 69120, -11520,
                            91903, -1, 2, 0, 131};
        sb = new();
        rst_n = 1'b0;
        calm = 1'b0;
        hold_asks = 0;
        settings = 1;
        sent = 0;
        req.valid = 1'b0;
        req.target_angle = '0;
        cfg.valid = 1'b0;
        cfg.reg_index = '0;
        cfg.write_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset defaults: zero move, sub-step move, bound edges, half turns
        foreach (opening_targets[i])
            send_target(bsasp_pkg::ANG_W'(opening_targets[i]));

        // narrow window, one step per degree: shorter way often leaves the bounds
        apply_setting(90 * 256, -90 * 256, 65536, 65536);
        run_targets(70, -1);
        // widest bounds, finest steps: long moves saturate the step count
        apply_setting(ANG_MAX, -ANG_MAX, 24'hFF_FFFF, 256);
        run_targets(50, -1);
        // lower above upper: everything rejected
        apply_setting(-100 * 256, 100 * 256, bsasp_pkg::SPD_RESET, bsasp_pkg::DPS_RESET);
        run_targets(20, -1);
        // zero degrees per step: never below one step
        apply_setting(ANG_MAX, -ANG_MAX, 65536, 0);
        run_targets(30, -1);
        // zero steps per degree: moves with zero steps
        apply_setting(180 * 256, -180 * 256, 0, bsasp_pkg::DPS_RESET);
        run_targets(25, -1);
        // coarsest degrees per step
        apply_setting(ANG_MAX, -ANG_MAX, 65536, 24'hFF_FFFF);
        run_targets(25, -1);
        // single-point window
        apply_setting(45 * 256, 45 * 256, bsasp_pkg::SPD_RESET, bsasp_pkg::DPS_RESET);
        run_targets(20, -1);
        apply_setting(bsasp_pkg::UPPER_RESET, bsasp_pkg::LOWER_RESET,
                      bsasp_pkg::SPD_RESET, bsasp_pkg::DPS_RESET);
        run_targets(40, -1);

        for (int p = 0; p < 10; p++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                a = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
                b = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
                ub = (a > b) ? a : b;
                lb = (a > b) ? b : a;
            end
            else
            begin
                ub = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
                lb = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
            end
            if ($urandom_range(0, 9) == 0)
                spd_v = $urandom_range(0, (1 << bsasp_pkg::SCALE_W) - 1);
            else
                spd_v = $urandom_range(1 << 16, (1 << bsasp_pkg::SCALE_W) - 1);
            // keep the two scales roughly consistent, off by a count at most
            if (spd_v == 0)
                dps_v = $urandom_range(0, (1 << bsasp_pkg::SCALE_W) - 1);
            else
                dps_v = (64'd1 << 32) / spd_v + $urandom_range(0, 2);
            if (dps_v > 0)
                dps_v = dps_v - 1;
            if (dps_v > (1 << bsasp_pkg::SCALE_W) - 1)
                dps_v = (1 << bsasp_pkg::SCALE_W) - 1;
            apply_setting(ub, lb, spd_v, dps_v);
            if (p == 4)
            begin
                // no idling on either side; results held back so the core backs up
                calm <= 1'b1;
                hold_asks <= hold_asks + 1;
            end
            run_targets(65, (p == 2) ? 30 : -1);
            calm <= 1'b0;
        end

        wait_drain();
        repeat (20) @(negedge clk);
        $display("%0d targets over %0d register settings: %0d moved, %0d below one step,",
                 sent, settings, sb.n_moved, sb.n_below);
        $display("%0d out of range; %0d results checked, %0d mismatches",
                 sb.n_range, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
